FILE: rtl/modular_inverse_ext_euclid_unit_macros.svh
// assertion macros for the modular inverse unit
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_MACROS_SVH

// same-cycle implication
`define MIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mie_pkg.sv
// shared constants for the modular inverse unit
`default_nettype none

package mie_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int FIELD_W   = 32;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_COPRIME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/modular_inverse_ext_euclid_unit.sv
// modular inverse by extended euclid: top level with sequencer and datapath
// one quotient bit per cycle in the subtract state, through the single shared
// compare/subtract unit; the next word is taken only once the unit is idle again
// reset: synchronous active-low, clears the sequencer and the result valid
`default_nettype none
`include "modular_inverse_ext_euclid_unit_macros.svh"

module modular_inverse_ext_euclid_unit #(
  parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mie_pkg::FIELD_W-1:0]   in_modulus,
  input  wire logic [mie_pkg::FIELD_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mie_pkg::FIELD_W-1:0]        out_inverse,
  output logic [mie_pkg::STATUS_W-1:0]       out_status
);

  localparam int FW = mie_pkg::FIELD_W;
  localparam int KW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_ALIGN, S_SUB, S_STEP, S_TERM, S_NEG, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [FW-1:0] out_inverse_r, out_inverse_nxt;
  logic [mie_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [WIDTH-1:0] ta_r, ta_nxt, tb_r, tb_nxt;
  logic [WIDTH-1:0] d_r, d_nxt, ts_r, ts_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt, tc_r, tc_nxt;
  logic [WIDTH-1:0] inv_r, inv_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             neg_a_r, neg_a_nxt, neg_b_r, neg_b_nxt;
  logic [mie_pkg::STATUS_W-1:0] st_r, st_nxt;

  logic [WIDTH+FW-1:0] mod_ext, val_ext;
  logic [WIDTH-1:0]    m_in, v_in;
  logic [FW+WIDTH-1:0] inv_ext;
  logic [WIDTH-1:0]    cmp_a, cmp_b, diff, sum;
  logic                ge;
  logic                in_take, out_free;

  assign mod_ext = {{WIDTH{1'b0}}, in_modulus};
  assign val_ext = {{WIDTH{1'b0}}, in_value};
  assign m_in    = mod_ext[WIDTH-1:0];
  assign v_in    = val_ext[WIDTH-1:0];
  assign inv_ext = {{FW{1'b0}}, inv_r};

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (state_r)
      S_ALIGN: begin
        cmp_a = rem_r;
        cmp_b = {d_r[WIDTH-2:0], 1'b0};
      end
      S_TERM: begin
        cmp_a = ta_r;
        cmp_b = m_r;
      end
      S_NEG: begin
        cmp_a = m_r;
        cmp_b = ta_r;
      end
      default: begin
        cmp_a = rem_r;
        cmp_b = d_r;
      end
    endcase
  end

  mie_alu #(.WIDTH(WIDTH)) u_alu (
    .cmp_a (cmp_a),
    .cmp_b (cmp_b),
    .add_a (tc_r),
    .add_b (ts_r),
    .ge    (ge),
    .diff  (diff),
    .sum   (sum)
  );

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_inverse_nxt = out_inverse_r;
    out_status_nxt  = out_status_r;
    m_nxt     = m_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    d_nxt     = d_r;
    ts_nxt    = ts_r;
    rem_nxt   = rem_r;
    tc_nxt    = tc_r;
    inv_nxt   = inv_r;
    k_nxt     = k_r;
    neg_a_nxt = neg_a_r;
    neg_b_nxt = neg_b_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          m_nxt     = m_in;
          ra_nxt    = m_in;
          rb_nxt    = v_in;
          ta_nxt    = '0;
          tb_nxt    = WIDTH'(1);
          neg_a_nxt = 1'b0;
          neg_b_nxt = 1'b0;
          inv_nxt   = '0;
          if ((m_in < WIDTH'(2)) || (v_in == '0)) begin
            st_nxt    = mie_pkg::ST_INVALID;
            state_nxt = S_FIN;
          end else begin
            st_nxt    = mie_pkg::ST_OK;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (rb_r == '0) begin
          state_nxt = S_TERM;
        end else begin
          d_nxt     = rb_r;
          ts_nxt    = tb_r;
          rem_nxt   = ra_r;
          tc_nxt    = ta_r;
          k_nxt     = '0;
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (!d_r[WIDTH-1] && ge) begin
          d_nxt  = {d_r[WIDTH-2:0], 1'b0};
          ts_nxt = {ts_r[WIDTH-2:0], 1'b0};
          k_nxt  = k_r + KW'(1);
        end else begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        if (ge) begin
          rem_nxt = diff;
          tc_nxt  = sum;
        end
        if (k_r == '0) begin
          state_nxt = S_STEP;
        end else begin
          d_nxt  = {1'b0, d_r[WIDTH-1:1]};
          ts_nxt = {1'b0, ts_r[WIDTH-1:1]};
          k_nxt  = k_r - KW'(1);
        end
      end
      S_STEP: begin
        ra_nxt    = rb_r;
        rb_nxt    = rem_r;
        ta_nxt    = tb_r;
        tb_nxt    = tc_r;
        neg_a_nxt = neg_b_r;
        neg_b_nxt = !neg_b_r;
        state_nxt = S_CHECK;
      end
      S_TERM: begin
        if (ra_r != WIDTH'(1)) begin
          st_nxt    = mie_pkg::ST_NOT_COPRIME;
          state_nxt = S_FIN;
        end else begin
          if (ge) begin
            ta_nxt = diff;
          end
          state_nxt = S_NEG;
        end
      end
      S_NEG: begin
        inv_nxt   = (neg_a_r && (ta_r != '0)) ? diff : ta_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_inverse_nxt = inv_ext[FW-1:0];
          out_status_nxt  = st_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_inverse_r <= out_inverse_nxt;
    out_status_r  <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    ta_r    <= ta_nxt;
    tb_r    <= tb_nxt;
    d_r     <= d_nxt;
    ts_r    <= ts_nxt;
    rem_r   <= rem_nxt;
    tc_r    <= tc_nxt;
    inv_r   <= inv_nxt;
    k_r     <= k_nxt;
    neg_a_r <= neg_a_nxt;
    neg_b_r <= neg_b_nxt;
    st_r    <= st_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;
  assign out_status  = out_status_r;

  `MIE_ASSERT_NEXT(a_take_busy, in_take, state_r != S_IDLE, "unit idle after taking a word")
  `MIE_ASSERT_NOW(a_rem_below_div, state_r == S_STEP, rem_r < rb_r, "remainder not below divisor")
  `MIE_ASSERT_NEXT(a_sub_done, (state_r == S_SUB) && (k_r == '0), state_r == S_STEP, "division did not end")
  `MIE_ASSERT_NOW(a_bad_zero, out_valid_r && (out_status_r != mie_pkg::ST_OK), out_inverse_r == '0, "nonzero inverse on error")

endmodule

`default_nettype wire

FILE: rtl/mie_alu.sv
// shared compare, subtract and add unit for the euclid sequencer
`default_nettype none

module mie_alu #(
  parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
  input  wire logic [WIDTH-1:0] cmp_a,
  input  wire logic [WIDTH-1:0] cmp_b,
  input  wire logic [WIDTH-1:0] add_a,
  input  wire logic [WIDTH-1:0] add_b,
  output logic                  ge,
  output logic [WIDTH-1:0]      diff,
  output logic [WIDTH-1:0]      sum
);

  assign ge   = (cmp_a >= cmp_b);
  assign diff = cmp_a - cmp_b;
  assign sum  = add_a + add_b;

endmodule

`default_nettype wire

FILE: test/modular_inverse_ext_euclid_unit_tb.sv
// self-checking testbench for the extended euclid modular inverse unit
module modular_inverse_ext_euclid_unit_tb;

  localparam int FIELD_W      = mie_pkg::FIELD_W;
  localparam int STATUS_W     = mie_pkg::STATUS_W;
  localparam int N_RANDOM     = 430;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [FIELD_W-1:0]  modulus;
    logic [FIELD_W-1:0]  value;
    logic                typed;
    logic [FIELD_W-1:0]  inverse;
    logic [STATUS_W-1:0] status;
  } operand_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  modulus;
    logic [FIELD_W-1:0]  value;
    logic [FIELD_W-1:0]  inverse;
    logic [STATUS_W-1:0] status;
  } inverse_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [FIELD_W-1:0]  in_modulus;
  logic [FIELD_W-1:0]  in_value;
  logic                out_valid;
  logic                out_stall;
  logic [FIELD_W-1:0]  out_inverse;
  logic [STATUS_W-1:0] out_status;

  operand_t operand_q[$];
  inverse_t inverse_q[$];
  operand_t pending_word;
  int       next_idx;
  int       sent_cnt;
  int       recv_cnt;
  int       mismatch_cnt;
  int       idle_cycles;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       ok_cnt;
  int       coprime_fail_cnt;
  int       invalid_cnt;

  modular_inverse_ext_euclid_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_modulus  (in_modulus),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_inverse (out_inverse),
    .out_status  (out_status)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic inverse_t mod_inverse(logic [FIELD_W-1:0] m, logic [FIELD_W-1:0] v);
    logic [63:0] ra, rb, ta, tb, q, rc, tc, m64;
    logic        neg_a, neg_b;
    inverse_t    r;
    r.modulus = m;
    r.value   = v;
    r.inverse = '0;
    r.status  = mie_pkg::ST_OK;
    m64 = {32'b0, m};
    if (m < 2 || v == 0) begin
      r.status = mie_pkg::ST_INVALID;
    end else begin
      ra = m64;
      rb = {32'b0, v} % m64;
      ta = 64'd0;
      tb = 64'd1;
      neg_a = 1'b0;
      neg_b = 1'b0;
      while (rb != 0) begin
        q  = ra / rb;
        rc = ra % rb;
        tc = ta + q * tb;
        ra = rb;
        rb = rc;
        ta = tb;
        tb = tc;
        neg_a = neg_b;
        neg_b = ~neg_b;
      end
      if (ra != 1) begin
        r.status = mie_pkg::ST_NOT_COPRIME;
      end else begin
        if (ta >= m64) ta = ta % m64;
        r.inverse = (neg_a && ta != 0) ? FIELD_W'(m64 - ta) : FIELD_W'(ta);
      end
    end
    return r;
  endfunction

  task automatic add_word(logic [FIELD_W-1:0] m, logic [FIELD_W-1:0] v, logic typed,
                          logic [FIELD_W-1:0] inv, logic [STATUS_W-1:0] st);
    operand_t w;
    w.modulus = m;
    w.value   = v;
    w.typed   = typed;
    w.inverse = inv;
    w.status  = st;
    operand_q.push_back(w);
  endtask

  task automatic add_random_word();
    logic [FIELD_W-1:0] f, m, v;
    int                 kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      if ($urandom_range(1)) begin
        m = $urandom_range(1);
        v = $urandom;
      end else begin
        m = $urandom;
        v = '0;
      end
    end else if (kind < 22) begin
      // shared factor, so no inverse exists
      f = $urandom_range(1000, 2);
      m = f * $urandom_range(32'hFFFF_FFFF / f, 1);
      v = f * $urandom_range(32'hFFFF_FFFF / f, 1);
    end else if (kind < 36) begin
      m = $urandom_range(255, 2);
      v = $urandom;
    end else if (kind < 46) begin
      m = $urandom_range(65535, 2);
      v = $urandom_range(65535, 1);
    end else begin
      m = $urandom;
      v = $urandom;
    end
    add_word(m, v, 1'b0, '0, mie_pkg::ST_OK);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (pending_word.typed) begin
          inverse_q.push_back({pending_word.modulus, pending_word.value,
                               pending_word.inverse, pending_word.status});
        end else begin
          inverse_q.push_back(mod_inverse(pending_word.modulus, pending_word.value));
        end
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (next_idx < operand_q.size() && $urandom_range(99) >= send_idle_pct) begin
          pending_word = operand_q[next_idx];
          next_idx++;
          in_valid   <= 1'b1;
          in_modulus <= pending_word.modulus;
          in_value   <= pending_word.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    inverse_t exp_word;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        recv_cnt++;
        if (inverse_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: unexpected word inverse=%h status=%0d", out_inverse, out_status);
        end else begin
          exp_word = inverse_q.pop_front();
          case (exp_word.status)
            mie_pkg::ST_OK:          ok_cnt++;
            mie_pkg::ST_NOT_COPRIME: coprime_fail_cnt++;
            default:                 invalid_cnt++;
          endcase
          if (out_inverse !== exp_word.inverse || out_status !== exp_word.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: m=%h v=%h expected inverse=%h status=%0d, got inverse=%h status=%0d",
                       exp_word.modulus, exp_word.value, exp_word.inverse, exp_word.status,
                       out_inverse, out_status);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // idle phases
  always @(posedge clk) begin
    if (next_idx < operand_q.size() / 3) begin
      send_idle_pct = 19;
      recv_idle_pct = 47;
    end else if (next_idx < 2 * operand_q.size() / 3) begin
      send_idle_pct = 47;
      recv_idle_pct = 19;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_modulus   = '0;
    in_value     = '0;
    out_stall    = 1'b0;
    next_idx     = 0;
    sent_cnt     = 0;
    recv_cnt     = 0;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    ok_cnt       = 0;
    coprime_fail_cnt = 0;
    invalid_cnt  = 0;
    send_idle_pct = 19;
    recv_idle_pct = 47;

    // invalid operands
    add_word(32'd0,          32'd5,          1'b1, 32'd0,          mie_pkg::ST_INVALID);
    add_word(32'd1,          32'd1,          1'b1, 32'd0,          mie_pkg::ST_INVALID);
    add_word(32'd1,          32'd0,          1'b1, 32'd0,          mie_pkg::ST_INVALID);
    add_word(32'd0,          32'd0,          1'b1, 32'd0,          mie_pkg::ST_INVALID);
    add_word(32'hFFFF_FFFF,  32'd0,          1'b1, 32'd0,          mie_pkg::ST_INVALID);
    add_word(32'd7,          32'd0,          1'b1, 32'd0,          mie_pkg::ST_INVALID);
    // value one and self-inverse extremes
    add_word(32'd2,          32'd1,          1'b1, 32'd1,          mie_pkg::ST_OK);
    add_word(32'hFFFF_FFFF,  32'd1,          1'b1, 32'd1,          mie_pkg::ST_OK);
    add_word(32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE,  mie_pkg::ST_OK);
    add_word(32'hFFFF_FFFE,  32'hFFFF_FFFD,  1'b1, 32'hFFFF_FFFD,  mie_pkg::ST_OK);
    add_word(32'd3,          32'd2,          1'b1, 32'd2,          mie_pkg::ST_OK);
    add_word(32'd2,          32'hFFFF_FFFF,  1'b1, 32'd1,          mie_pkg::ST_OK);
    // multiples of the modulus and shared factors
    add_word(32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0,          mie_pkg::ST_NOT_COPRIME);
    add_word(32'd5,          32'd10,         1'b1, 32'd0,          mie_pkg::ST_NOT_COPRIME);
    add_word(32'd12,         32'd8,          1'b1, 32'd0,          mie_pkg::ST_NOT_COPRIME);
    add_word(32'h5555_5555,  32'hAAAA_AAAA,  1'b1, 32'd0,          mie_pkg::ST_NOT_COPRIME);
    // general cases, value above modulus, long euclid chains
    add_word(32'd7,          32'd3,          1'b0, '0, mie_pkg::ST_OK);
    add_word(32'd7,          32'd10,         1'b0, '0, mie_pkg::ST_OK);
    add_word(32'hFFFF_FFFB,  32'd2,          1'b0, '0, mie_pkg::ST_OK);
    add_word(32'd2971215073, 32'd1836311903, 1'b0, '0, mie_pkg::ST_OK);
    add_word(32'h8000_0000,  32'h7FFF_FFFF,  1'b0, '0, mie_pkg::ST_OK);
    add_word(32'd1000000007, 32'hDEAD_BEEF,  1'b0, '0, mie_pkg::ST_OK);
    add_word(32'hFFFF_FFFF,  32'h8000_0000,  1'b0, '0, mie_pkg::ST_OK);
    add_word(32'd97,         32'hFFFF_FFFF,  1'b0, '0, mie_pkg::ST_OK);
    repeat (N_RANDOM) add_random_word();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < operand_q.size()) @(posedge clk);
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d words: %0d inverses, %0d without inverse, %0d invalid operands",
             recv_cnt, ok_cnt, coprime_fail_cnt, invalid_cnt);
    $display("mismatches: %0d", mismatch_cnt);
    if (mismatch_cnt == 0 && inverse_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/mie_pkg.sv
rtl/mie_alu.sv
rtl/modular_inverse_ext_euclid_unit.sv
test/modular_inverse_ext_euclid_unit_tb.sv
